FILE: hdl/otsu_pkg.sv
// Shared types and constants for the Otsu threshold block.
`default_nettype none

package otsu_pkg;

  // Fixed field widths of the channels
  localparam int COUNT_PORT_W = 20;
  localparam int THR_W        = 4;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_ACC,
    ST_CHECK,
    ST_MUL_GO,
    ST_MUL_RUN,
    ST_FINISH
  } state_t;

  // Products formed for one candidate split, in issue order
  typedef enum logic [2:0] {
    MUL_X,
    MUL_Y,
    MUL_D2,
    MUL_P,
    MUL_LHS,
    MUL_RHS
  } mul_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    acc;
    logic    next_t;
    logic    mul_start;
    logic    mul_capture;
    mul_op_t mul_op;
    logic    out_load;
    logic    frame_clear;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic wb_zero;
    logic wf_zero;
    logic last_t;
    logic mul_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/otsu_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module otsu_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/otsu_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, stops when the rest is zero.
`default_nettype none

module otsu_mul #(
  parameter int AW = 144,
  parameter int BW = 49
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [AW-1:0] a_in,
  input  wire logic [BW-1:0] b_in,
  output logic               busy,
  output logic      [AW-1:0] product
);

  logic [AW-1:0] a_sh;
  logic [BW-1:0] b_sh;

  assign busy = (b_sh != '0);

  // Multiplier bits left to consume
  always_ff @(posedge clk) begin
    if (rst) begin
      b_sh <= '0;
    end else if (start) begin
      b_sh <= b_in;
    end else if (busy) begin
      b_sh <= b_sh >> 1;
    end
  end

  // Shifted multiplicand and running sum
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh    <= a_in;
      product <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        product <= product + a_sh;
      end
      a_sh <= a_sh << 1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/otsu_dp.sv
// Datapath: bin store, frame sums, scan sums, product registers and best split.
`default_nettype none

module otsu_dp #(
  parameter int BINS        = 8,
  parameter int COUNT_WIDTH = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire otsu_pkg::cmd_t                   cmd,
  output otsu_pkg::status_t                     status,
  input  wire logic [otsu_pkg::COUNT_PORT_W-1:0] bin_count,
  output logic      [otsu_pkg::THR_W-1:0]        threshold
);
  import otsu_pkg::*;

  localparam int CW = (COUNT_WIDTH < COUNT_PORT_W) ? COUNT_WIDTH : COUNT_PORT_W;
  localparam int IW = $clog2(BINS);
  localparam int NW = $clog2(BINS + 1);
  localparam int TW = CW + IW;          // pixel total and class weights
  localparam int SW = CW + 2 * IW;      // index-weighted sums
  localparam int XW = SW + TW;          // cross products and their difference
  localparam int PW = 2 * XW + 2 * TW;  // widest compare product

  // Frame state
  logic [NW-1:0] load_idx;
  logic [TW-1:0] total;
  logic [SW-1:0] wsum;

  // Scan state
  logic [IW-1:0]     t;
  logic [IW:0]       t_plus;
  logic [TW-1:0]     wb;
  logic [TW-1:0]     wf;
  logic [SW-1:0]     sumb;
  logic [XW-1:0]     x_reg;
  logic [XW-1:0]     d;
  logic [2*XW-1:0]   d2;
  logic [2*TW-1:0]   p;
  logic [PW-1:0]     lhs;
  logic [2*XW-1:0]   best_num;
  logic [2*TW-1:0]   best_den;
  logic [IW:0]       thr;

  logic [CW-1:0]     cnt;
  logic              wr_en;
  logic [IW+CW-1:0]  load_prod;
  logic [CW-1:0]     h;
  logic [IW+CW-1:0]  th_prod;
  logic [XW-1:0]     y_val;

  logic [PW-1:0]     mul_a;
  logic [XW-1:0]     mul_b;
  logic              mul_busy;
  logic [PW-1:0]     mul_p;

  assign cnt       = bin_count[CW-1:0];
  assign wr_en     = cmd.load && (load_idx < NW'(BINS));
  assign load_prod = load_idx[IW-1:0] * cnt;
  assign th_prod   = t * h;
  assign t_plus    = {1'b0, t} + 1'b1;
  assign wf        = total - wb;
  assign y_val     = mul_p[XW-1:0];

  otsu_ram #(
    .WIDTH (CW),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (wr_en),
    .waddr (load_idx[IW-1:0]),
    .wdata (cnt),
    .raddr (t),
    .rdata (h)
  );

  // Pick the operands of the next product
  always_comb begin
    case (cmd.mul_op)
      MUL_X: begin
        mul_a = PW'(sumb);
        mul_b = XW'(total);
      end
      MUL_Y: begin
        mul_a = PW'(wsum);
        mul_b = XW'(wb);
      end
      MUL_D2: begin
        mul_a = PW'(d);
        mul_b = d;
      end
      MUL_P: begin
        mul_a = PW'(wb);
        mul_b = XW'(wf);
      end
      MUL_LHS: begin
        mul_a = PW'(d2);
        mul_b = XW'(best_den);
      end
      MUL_RHS: begin
        mul_a = PW'(best_num);
        mul_b = XW'(p);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otsu_mul #(
    .AW (PW),
    .BW (XW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .busy    (mul_busy),
    .product (mul_p)
  );

  // Accumulate the frame on each stored beat, drop it after the scan
  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      load_idx <= '0;
      total    <= '0;
      wsum     <= '0;
    end else if (wr_en) begin
      load_idx <= load_idx + 1'b1;
      total    <= total + TW'(cnt);
      wsum     <= wsum + SW'(load_prod);
    end
  end

  // Scan registers
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      t        <= '0;
      wb       <= '0;
      sumb     <= '0;
      best_num <= '0;
      best_den <= (2*TW)'(1);
      thr      <= '0;
    end else begin
      if (cmd.acc) begin
        wb   <= wb + TW'(h);
        sumb <= sumb + SW'(th_prod);
      end
      if (cmd.next_t) begin
        t <= t_plus[IW-1:0];
      end
      if (cmd.mul_capture) begin
        case (cmd.mul_op)
          MUL_X:   x_reg <= mul_p[XW-1:0];
          MUL_Y:   d     <= (x_reg >= y_val) ? (x_reg - y_val) : (y_val - x_reg);
          MUL_D2:  d2    <= mul_p[2*XW-1:0];
          MUL_P:   p     <= mul_p[2*TW-1:0];
          MUL_LHS: lhs   <= mul_p;
          MUL_RHS: begin
            // Keep the first strictly larger variance
            if (lhs > mul_p) begin
              best_num <= d2;
              best_den <= p;
              thr      <= t_plus;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      threshold <= THR_W'(thr);
    end
  end

  assign status.wb_zero  = (wb == '0);
  assign status.wf_zero  = (wb == total);
  assign status.last_t   = (t_plus == (IW+1)'(load_idx));
  assign status.mul_busy = mul_busy;

  a_load_idx_range: assert property (@(posedge clk) disable iff (rst)
    load_idx <= NW'(BINS))
    else $error("bin count ran past the store depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> ({1'b0, t} < (IW+1)'(load_idx)))
    else $error("scan read a bin that was not stored in this frame");

endmodule

`default_nettype wire

FILE: hdl/otsu_ctrl.sv
// Controller: load bins, step the scan, sequence the products, deliver the result.
`default_nettype none

module otsu_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                last_bin,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire otsu_pkg::status_t   status,
  output otsu_pkg::cmd_t           cmd
);
  import otsu_pkg::*;

  state_t  state, state_next;
  mul_op_t mul_op, mul_op_next;
  logic    in_take;
  logic    out_free;

  assign in_stall = (state != ST_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      mul_op <= MUL_X;
    end else begin
      state  <= state_next;
      mul_op <= mul_op_next;
    end
  end

  // Result valid: set on load, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    mul_op_next = mul_op;
    cmd         = '0;
    cmd.mul_op  = mul_op;
    case (state)
      ST_LOAD: begin
        if (in_take) begin
          cmd.load = 1'b1;
          if (last_bin) begin
            cmd.scan_init = 1'b1;
            state_next    = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.wb_zero) begin
          // Empty background so far: skip this split
          if (status.last_t) begin
            state_next = ST_FINISH;
          end else begin
            cmd.next_t = 1'b1;
            state_next = ST_FETCH;
          end
        end else if (status.wf_zero) begin
          state_next = ST_FINISH;
        end else begin
          mul_op_next = MUL_X;
          state_next  = ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        if (!status.mul_busy) begin
          cmd.mul_capture = 1'b1;
          case (mul_op)
            MUL_X:   mul_op_next = MUL_Y;
            MUL_Y:   mul_op_next = MUL_D2;
            MUL_D2:  mul_op_next = MUL_P;
            MUL_P:   mul_op_next = MUL_LHS;
            MUL_LHS: mul_op_next = MUL_RHS;
            default: mul_op_next = MUL_X;
          endcase
          if (mul_op == MUL_RHS) begin
            if (status.last_t) begin
              state_next = ST_FINISH;
            end else begin
              cmd.next_t = 1'b1;
              state_next = ST_FETCH;
            end
          end else begin
            state_next = ST_MUL_GO;
          end
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd.out_load    = 1'b1;
          cmd.frame_clear = 1'b1;
          state_next      = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  a_last_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_take && last_bin) |=> (state == ST_FETCH))
    else $error("final bin did not start the scan");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result appeared outside the finish step");

endmodule

`default_nettype wire

FILE: hdl/otsu_threshold_from_histogram.sv
// Top level of the Otsu threshold block: controller plus datapath.
//
//   channel  beat                    valid      stall      direction
//   input    bin_count, last_bin     in_valid   in_stall   into block
//   output   threshold               out_valid  out_stall  out of block
//
// Bins load at one beat per cycle; a final bin starts the scan, during which
// in_stall is high. Each candidate split runs on the one shared shift-add
// multiplier, with TW = CW + log2(BINS), XW = 2*CW + 3*log2(BINS) and
// CW = min(COUNT_WIDTH, 20). A frame's result waits in the output register;
// bins of the next frame are taken meanwhile. Reset is synchronous and
// empties the frame.
`default_nettype none

module otsu_threshold_from_histogram #(
  parameter int BINS        = 8,
  parameter int COUNT_WIDTH = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [otsu_pkg::COUNT_PORT_W-1:0] bin_count,
  input  wire logic                              last_bin,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [otsu_pkg::THR_W-1:0]        threshold
);
  import otsu_pkg::*;

  cmd_t    cmd;
  status_t status;

  otsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_bin  (last_bin),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  otsu_dp #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .bin_count (bin_count),
    .threshold (threshold)
  );

endmodule

`default_nettype wire
